FILE: src/grid_bfs_stepper_unit_assert.svh
// Assertion macros shared by the checker of the grid search stepper
`ifndef GRID_BFS_STEPPER_UNIT_ASSERT_SVH
`define GRID_BFS_STEPPER_UNIT_ASSERT_SVH

// same-cycle implication, masked during reset
`define GBFS_ASSERT_NOW(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("assertion failed");

// next-cycle implication, masked during reset
`define GBFS_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("assertion failed");

// next-cycle implication that also holds across reset
`define GBFS_ASSERT_NEXT_ALWAYS(lbl, pre, post) \
  lbl: assert property (@(posedge clk) (pre) |=> (post)) \
    else $error("assertion failed");

`endif

FILE: src/gbfs_pkg.sv
// Types and constants of the grid search stepper
package gbfs_pkg;

  localparam int COORD_W    = 6;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 7;

  typedef enum logic [1:0] {
    FN_WRITE   = 2'd0,
    FN_RESTART = 2'd1,
    FN_STEP    = 2'd2,
    FN_READ    = 2'd3
  } func_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GRID_WIDTH  = 3'd0,
    CFG_GRID_HEIGHT = 3'd1,
    CFG_START_X     = 3'd2,
    CFG_START_Y     = 3'd3,
    CFG_END_X       = 3'd4,
    CFG_END_Y       = 3'd5
  } cfg_reg_t;

  typedef enum logic [1:0] {
    NB_XP = 2'd0,
    NB_XM = 2'd1,
    NB_YP = 2'd2,
    NB_YM = 2'd3
  } nb_t;

  typedef enum logic [1:0] {
    MAD_ITEM = 2'd0,
    MAD_POP  = 2'd1,
    MAD_NB   = 2'd2
  } mad_sel_t;

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_RD,
    S_POP,
    S_CHK,
    S_NB,
    S_NBCHK,
    S_CLR,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [1:0]         func;
    logic [COORD_W-1:0] cell_x;
    logic [COORD_W-1:0] cell_y;
    logic               wall_bit;
  } in_item_t;

  typedef struct packed {
    logic [COORD_W-1:0] node_x;
    logic [COORD_W-1:0] node_y;
    logic               search_ended;
    logic               target_found;
    logic               visited_bit;
  } out_item_t;

  typedef struct packed {
    logic     ld_item;
    mad_sel_t mad_sel;
    logic     wall_we_item;
    logic     wall_clr;
    logic     seen_clr;
    logic     seen_set;
    logic     q_rst;
    logic     q_pop;
    logic     q_push_nb;
    logic     q_push_start;
    logic     cur_ld;
    logic     cur_clr;
    logic     flags_clr;
    logic     set_ended;
    logic     set_found;
    logic     vbit_ld;
    logic     sweep_inc;
    logic     nb_rst;
    logic     nb_inc;
    logic     out_ld;
  } cmd_t;

  typedef struct packed {
    logic q_empty;
    logic ended;
    logic wall_hit;
    logic is_end;
    logic nb_in_grid;
    logic nb_last;
    logic sweep_last;
    logic out_free;
  } sts_t;

endpackage

FILE: src/gbfs_ram.sv
// Generic single-write, single-read RAM with registered read data
module gbfs_ram #(
  parameter int W = 1,
  parameter int D = 4096
) (
  input  logic                            clk,
  input  logic                            we,
  input  logic [(D > 1 ? $clog2(D) : 1)-1:0] waddr,
  input  logic [W-1:0]                    wdata,
  input  logic [(D > 1 ? $clog2(D) : 1)-1:0] raddr,
  output logic [W-1:0]                    rdata
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: src/gbfs_ctrl.sv
// Sequencer of the grid search stepper
module gbfs_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [1:0]          in_func,
  input  gbfs_pkg::sts_t      sts,
  output gbfs_pkg::cmd_t      cmd
);

  gbfs_pkg::state_t state_r, state_nxt;
  logic             accept;

  assign in_stall = (state_r != gbfs_pkg::S_IDLE);
  assign accept   = in_valid && (state_r == gbfs_pkg::S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= gbfs_pkg::S_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      gbfs_pkg::S_INIT: begin
        if (sts.sweep_last) state_nxt = gbfs_pkg::S_IDLE;
      end
      gbfs_pkg::S_IDLE: begin
        if (accept) begin
          case (in_func)
            gbfs_pkg::FN_WRITE:   state_nxt = gbfs_pkg::S_DONE;
            gbfs_pkg::FN_RESTART: state_nxt = gbfs_pkg::S_CLR;
            gbfs_pkg::FN_STEP: begin
              if (sts.q_empty || sts.ended) state_nxt = gbfs_pkg::S_DONE;
              else state_nxt = gbfs_pkg::S_POP;
            end
            default: state_nxt = gbfs_pkg::S_RD;
          endcase
        end
      end
      gbfs_pkg::S_RD:  state_nxt = gbfs_pkg::S_DONE;
      gbfs_pkg::S_POP: state_nxt = gbfs_pkg::S_CHK;
      gbfs_pkg::S_CHK: begin
        if (sts.wall_hit || sts.is_end) state_nxt = gbfs_pkg::S_DONE;
        else state_nxt = gbfs_pkg::S_NB;
      end
      gbfs_pkg::S_NB: begin
        if (sts.nb_in_grid) state_nxt = gbfs_pkg::S_NBCHK;
        else if (sts.nb_last) state_nxt = gbfs_pkg::S_DONE;
      end
      gbfs_pkg::S_NBCHK: begin
        if (sts.nb_last) state_nxt = gbfs_pkg::S_DONE;
        else state_nxt = gbfs_pkg::S_NB;
      end
      gbfs_pkg::S_CLR: begin
        if (sts.sweep_last) state_nxt = gbfs_pkg::S_DONE;
      end
      gbfs_pkg::S_DONE: begin
        if (sts.out_free) state_nxt = gbfs_pkg::S_IDLE;
      end
      default: state_nxt = gbfs_pkg::S_INIT;
    endcase
  end

  always_comb begin
    cmd         = '0;
    cmd.mad_sel = gbfs_pkg::MAD_ITEM;
    case (state_r)
      gbfs_pkg::S_INIT: begin
        cmd.wall_clr  = 1'b1;
        cmd.seen_clr  = 1'b1;
        cmd.sweep_inc = 1'b1;
      end
      gbfs_pkg::S_IDLE: begin
        if (accept) begin
          cmd.ld_item = 1'b1;
          case (in_func)
            gbfs_pkg::FN_WRITE: cmd.wall_we_item = 1'b1;
            gbfs_pkg::FN_RESTART: begin
              cmd.q_rst     = 1'b1;
              cmd.flags_clr = 1'b1;
              cmd.cur_clr   = 1'b1;
            end
            gbfs_pkg::FN_STEP: begin
              // an empty queue ends the search; an ended search holds
              if (sts.q_empty) cmd.set_ended = 1'b1;
              else if (!sts.ended) cmd.q_pop = 1'b1;
            end
            default: cmd.mad_sel = gbfs_pkg::MAD_ITEM;
          endcase
        end
      end
      gbfs_pkg::S_RD: cmd.vbit_ld = 1'b1;
      gbfs_pkg::S_POP: begin
        cmd.cur_ld  = 1'b1;
        cmd.mad_sel = gbfs_pkg::MAD_POP;
      end
      gbfs_pkg::S_CHK: begin
        if (!sts.wall_hit) begin
          cmd.seen_set = 1'b1;
          if (sts.is_end) begin
            cmd.set_ended = 1'b1;
            cmd.set_found = 1'b1;
          end else begin
            cmd.nb_rst = 1'b1;
          end
        end
      end
      gbfs_pkg::S_NB: begin
        cmd.mad_sel = gbfs_pkg::MAD_NB;
        if (!sts.nb_in_grid && !sts.nb_last) cmd.nb_inc = 1'b1;
      end
      gbfs_pkg::S_NBCHK: begin
        cmd.q_push_nb = !sts.wall_hit;
        cmd.nb_inc    = !sts.nb_last;
      end
      gbfs_pkg::S_CLR: begin
        cmd.seen_clr     = 1'b1;
        cmd.sweep_inc    = 1'b1;
        cmd.q_push_start = sts.sweep_last;
      end
      gbfs_pkg::S_DONE: cmd.out_ld = sts.out_free;
      default: cmd.mad_sel = gbfs_pkg::MAD_ITEM;
    endcase
  end

endmodule

FILE: src/gbfs_dpath.sv
// Datapath of the grid search stepper: maps, queue, counters and result register
module gbfs_dpath #(
  parameter int GRID_SIDE   = 64,
  parameter int QUEUE_DEPTH = 16384
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_valid,
  input  logic [gbfs_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [gbfs_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  gbfs_pkg::in_item_t                in_data,
  output logic                              out_valid,
  input  logic                              out_stall,
  output gbfs_pkg::out_item_t               out_data,
  input  gbfs_pkg::cmd_t                    cmd,
  output gbfs_pkg::sts_t                    sts
);

  localparam int XW   = $clog2(GRID_SIDE);
  localparam int PW   = XW + 8;
  localparam int N    = GRID_SIDE * GRID_SIDE;
  localparam int AW   = $clog2(N);
  localparam int QAW  = $clog2(QUEUE_DEPTH);
  localparam int CNTW = $clog2(QUEUE_DEPTH + 1);
  localparam int EW   = 2 * XW;
  localparam logic [PW-1:0]   GS_P   = PW'(GRID_SIDE);
  localparam logic [CNTW:0]   QD_S   = (CNTW + 1)'(QUEUE_DEPTH);
  localparam logic [CNTW-1:0] QD_C   = CNTW'(QUEUE_DEPTH);
  localparam logic [QAW-1:0]  QLAST  = QAW'(QUEUE_DEPTH - 1);
  localparam logic [AW-1:0]   SLAST  = AW'(N - 1);

  function automatic logic [AW-1:0] cell_addr(logic [XW-1:0] x, logic [XW-1:0] y);
    return AW'(32'(y) * GRID_SIDE + 32'(x));
  endfunction

  // configuration
  logic [6:0] gw_r, gh_r;
  logic [5:0] sx_r, sy_r, ex_r, ey_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gw_r <= 7'd64;
      gh_r <= 7'd64;
      sx_r <= 6'd0;
      sy_r <= 6'd0;
      ex_r <= 6'd63;
      ey_r <= 6'd63;
    end else if (cfg_valid) begin
      case (cfg_index)
        gbfs_pkg::CFG_GRID_WIDTH:  gw_r <= cfg_data;
        gbfs_pkg::CFG_GRID_HEIGHT: gh_r <= cfg_data;
        gbfs_pkg::CFG_START_X:     sx_r <= cfg_data[5:0];
        gbfs_pkg::CFG_START_Y:     sy_r <= cfg_data[5:0];
        gbfs_pkg::CFG_END_X:       ex_r <= cfg_data[5:0];
        gbfs_pkg::CFG_END_Y:       ey_r <= cfg_data[5:0];
        default: ;
      endcase
    end
  end

  logic [PW-1:0] eff_w, eff_h;
  assign eff_w = (PW'(gw_r) > GS_P) ? GS_P : PW'(gw_r);
  assign eff_h = (PW'(gh_r) > GS_P) ? GS_P : PW'(gh_r);

  // search state
  logic [QAW-1:0]  head_r;
  logic [CNTW-1:0] count_r;
  logic [XW-1:0]   cur_x_r, cur_y_r;
  logic            ended_r, found_r, vbit_r, inr_r, out_valid_r;
  logic [AW-1:0]   sweep_r;
  gbfs_pkg::nb_t   nb_r;
  gbfs_pkg::out_item_t out_r;

  // map and queue ports
  logic          wall_we, seen_we, wall_q, seen_q, wall_wd, q_we;
  logic [AW-1:0] wall_wa, seen_wa, map_ra;
  logic [QAW-1:0] q_wa;
  logic [EW-1:0]  q_wd, q_rd;

  logic          in_inr, start_ok, q_full;
  logic [PW-1:0] nx, ny;
  logic [CNTW:0] tail_sum;

  assign in_inr   = (PW'(in_data.cell_x) < GS_P) && (PW'(in_data.cell_y) < GS_P);
  assign start_ok = (PW'(sx_r) < eff_w) && (PW'(sy_r) < eff_h);
  assign q_full   = (count_r >= QD_C);

  always_comb begin
    nx = PW'(cur_x_r);
    ny = PW'(cur_y_r);
    case (nb_r)
      gbfs_pkg::NB_XP: nx = PW'(cur_x_r) + PW'(1);
      gbfs_pkg::NB_XM: nx = PW'(cur_x_r) - PW'(1);
      gbfs_pkg::NB_YP: ny = PW'(cur_y_r) + PW'(1);
      default:         ny = PW'(cur_y_r) - PW'(1);
    endcase
  end

  // tail stays below twice the depth: one compare and subtract
  always_comb begin
    tail_sum = (CNTW + 1)'(head_r) + (CNTW + 1)'(count_r);
    if (tail_sum >= QD_S) tail_sum = tail_sum - QD_S;
  end
  assign q_wa = tail_sum[QAW-1:0];

  always_comb begin
    case (cmd.mad_sel)
      gbfs_pkg::MAD_POP: map_ra = cell_addr(q_rd[XW-1:0], q_rd[EW-1:XW]);
      gbfs_pkg::MAD_NB:  map_ra = cell_addr(nx[XW-1:0], ny[XW-1:0]);
      default: map_ra = cell_addr(XW'(in_data.cell_x), XW'(in_data.cell_y));
    endcase
  end

  assign wall_we = cmd.wall_clr || (cmd.wall_we_item && in_inr);
  assign wall_wa = cmd.wall_clr ? sweep_r
                 : cell_addr(XW'(in_data.cell_x), XW'(in_data.cell_y));
  assign wall_wd = cmd.wall_clr ? 1'b0 : in_data.wall_bit;
  assign seen_we = cmd.seen_clr || cmd.seen_set;
  assign seen_wa = cmd.seen_clr ? sweep_r : cell_addr(cur_x_r, cur_y_r);

  assign q_we = !q_full && (cmd.q_push_nb || (cmd.q_push_start && start_ok));
  assign q_wd = cmd.q_push_start ? {XW'(sy_r), XW'(sx_r)} : {ny[XW-1:0], nx[XW-1:0]};

  gbfs_ram #(.W(1), .D(N)) u_wall (
    .clk(clk), .we(wall_we), .waddr(wall_wa), .wdata(wall_wd),
    .raddr(map_ra), .rdata(wall_q)
  );

  gbfs_ram #(.W(1), .D(N)) u_seen (
    .clk(clk), .we(seen_we), .waddr(seen_wa), .wdata(!cmd.seen_clr),
    .raddr(map_ra), .rdata(seen_q)
  );

  gbfs_ram #(.W(EW), .D(QUEUE_DEPTH)) u_queue (
    .clk(clk), .we(q_we), .waddr(q_wa), .wdata(q_wd),
    .raddr(head_r), .rdata(q_rd)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= '0;
      count_r     <= '0;
      cur_x_r     <= '0;
      cur_y_r     <= '0;
      ended_r     <= 1'b0;
      found_r     <= 1'b0;
      vbit_r      <= 1'b0;
      inr_r       <= 1'b0;
      sweep_r     <= '0;
      nb_r        <= gbfs_pkg::NB_XP;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.q_rst) begin
        head_r  <= '0;
        count_r <= '0;
      end else if (cmd.q_pop) begin
        head_r  <= (head_r == QLAST) ? '0 : head_r + QAW'(1);
        count_r <= count_r - CNTW'(1);
      end else if (q_we) begin
        count_r <= count_r + CNTW'(1);
      end
      if (cmd.cur_clr) begin
        cur_x_r <= '0;
        cur_y_r <= '0;
      end else if (cmd.cur_ld) begin
        cur_x_r <= q_rd[XW-1:0];
        cur_y_r <= q_rd[EW-1:XW];
      end
      if (cmd.flags_clr) begin
        ended_r <= 1'b0;
        found_r <= 1'b0;
      end else begin
        if (cmd.set_ended) ended_r <= 1'b1;
        if (cmd.set_found) found_r <= 1'b1;
      end
      if (cmd.ld_item) begin
        vbit_r <= 1'b0;
        inr_r  <= in_inr;
      end else if (cmd.vbit_ld) begin
        vbit_r <= inr_r && (wall_q || seen_q);
      end
      if (cmd.sweep_inc) sweep_r <= (sweep_r == SLAST) ? '0 : sweep_r + AW'(1);
      if (cmd.nb_rst) nb_r <= gbfs_pkg::NB_XP;
      else if (cmd.nb_inc) nb_r <= gbfs_pkg::nb_t'(nb_r + 2'd1);
      if (cmd.out_ld) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_ld) begin
      out_r.node_x       <= 6'(cur_x_r);
      out_r.node_y       <= 6'(cur_y_r);
      out_r.search_ended <= ended_r;
      out_r.target_found <= found_r;
      out_r.visited_bit  <= vbit_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assign sts.q_empty    = (count_r == '0);
  assign sts.ended      = ended_r;
  assign sts.wall_hit   = wall_q || seen_q;
  assign sts.is_end     = (PW'(cur_x_r) == PW'(ex_r)) && (PW'(cur_y_r) == PW'(ey_r));
  assign sts.nb_in_grid = (nx < eff_w) && (ny < eff_h);
  assign sts.nb_last    = (nb_r == gbfs_pkg::NB_YM);
  assign sts.sweep_last = (sweep_r == SLAST);
  assign sts.out_free   = !out_valid_r || !out_stall;

endmodule

FILE: src/grid_bfs_stepper_unit.sv
// Step-wise breadth-first search over a 4-neighbour grid. One transaction in
// gives one transaction out. Wall and seen maps are GRID_SIDE*GRID_SIDE x 1 RAMs
// and the queue a QUEUE_DEPTH-entry RAM, all with one read port, so a step
// reads its neighbours one after another: a step pops a cell, checks it, then
// probes up to four neighbours, and a restart clears the seen map cell by cell.
// After reset both maps are swept clear, during which in_stall stays high;
// configuration writes are taken at any time.
module grid_bfs_stepper_unit #(
  parameter int GRID_SIDE   = 64,
  parameter int QUEUE_DEPTH = 16384
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  gbfs_pkg::in_item_t              in_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output gbfs_pkg::out_item_t             out_data,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [gbfs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [gbfs_pkg::CFG_DATA_W-1:0] cfg_data
);

  gbfs_pkg::cmd_t cmd;
  gbfs_pkg::sts_t sts;

  assign cfg_ready = 1'b1;

  gbfs_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .in_func(in_data.func), .sts(sts), .cmd(cmd)
  );

  gbfs_dpath #(.GRID_SIDE(GRID_SIDE), .QUEUE_DEPTH(QUEUE_DEPTH)) u_dpath (
    .clk(clk), .rst_n(rst_n),
    .cfg_valid(cfg_valid && cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_data(in_data), .out_valid(out_valid), .out_stall(out_stall),
    .out_data(out_data), .cmd(cmd), .sts(sts)
  );

endmodule

FILE: src/gbfs_checker.sv
// Port-level checker of the grid search stepper and its bind
`include "grid_bfs_stepper_unit_assert.svh"

module gbfs_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input gbfs_pkg::out_item_t out_data
);

  // hold a stalled result
  `GBFS_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid)
  // one transaction at a time: stall right after an accepted item
  `GBFS_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall)
  // the map sweep after reset blocks input
  `GBFS_ASSERT_NEXT_ALWAYS(a_init_sweep, !rst_n, in_stall)
  // a found target always means an ended search
  `GBFS_ASSERT_NOW(a_found_ended, out_valid && out_data.target_found,
                   out_data.search_ended)

endmodule

bind grid_bfs_stepper_unit gbfs_checker u_gbfs_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
);
